/* sv/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, reset disables.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* sv/drc_pkg.sv */
// Package: constants, register indexes and control types of the ray caster.
`default_nettype none
package drc_pkg;
   localparam int MAP_SIZE_DEF  = 32;
   localparam int MAX_STEPS_DEF = 64;

   localparam logic [2:0] REG_PLAYER_X = 3'd0;
   localparam logic [2:0] REG_PLAYER_Y = 3'd1;
   localparam logic [2:0] REG_VIEW_SIN = 3'd2;
   localparam logic [2:0] REG_VIEW_COS = 3'd3;
   localparam logic [2:0] REG_SCREEN_W = 3'd4;
   localparam logic [2:0] REG_SCREEN_H = 3'd5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   // Divider operand selects.
   localparam logic [2:0] DIV_CAM   = 3'd0;
   localparam logic [2:0] DIV_DDX   = 3'd1;
   localparam logic [2:0] DIV_DDY   = 3'd2;
   localparam logic [2:0] DIV_PERP  = 3'd3;
   localparam logic [2:0] DIV_LINE  = 3'd4;

   typedef struct packed {
      logic       load;       // latch request
      logic       prep;       // unused; w/h are clamped on load
      logic       div_go;     // start a divide
      logic [2:0] div_sel;
      logic       div_take;   // store divider result
      logic       dir_mul;    // multiply step for direction
      logic       dir_fin;    // finish direction
      logic       side_mul;   // side distances
      logic       walk;       // one DDA step
      logic       map_rd;     // read cell at current map position
      logic       fin;        // form result
   } drc_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_map;
      logic wall;
      logic d_zero;
      logic perp_zero;
   } drc_sts_type;
endpackage
`default_nettype wire

/* sv/drc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module drc_div import drc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [63:0] num,
   input  wire logic [31:0] den,
   output logic             done,
   output logic [63:0]      quo
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [32:0] sh;

   always_comb begin
      q_in = q_ff; r_in = r_ff; den_in = den_ff; cnt_in = cnt_ff; run_in = run_ff;
      sh = {r_ff[31:0], q_ff[63]};
      if (go) begin
         q_in = num; r_in = '0; den_in = den; cnt_in = 7'd64; run_in = 1'b1;
      end else if (run_ff) begin
         if (sh >= {1'b0, den_ff}) begin
            r_in = sh - {1'b0, den_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0; run_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; run_ff <= run_in;
      end
   end

   assign done = run_ff && (cnt_ff == 7'd1);
   assign quo  = q_in;
endmodule
`default_nettype wire

/* sv/drc_datapath.sv */
// Datapath: config registers, map memory, divider, DDA and result registers.
`default_nettype none
module drc_datapath import drc_pkg::*; #(
   parameter int MAP_SIZE = MAP_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        map_we,
   input  wire logic [4:0]  wr_x,
   input  wire logic [4:0]  wr_y,
   input  wire logic [7:0]  wr_val,
   input  wire logic        clr_we,
   input  wire logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0] clr_addr,
   input  wire logic [9:0]  req_column,
   input  drc_cmd_type      cmd,
   input  wire logic        escaped_set,
   output drc_sts_type      sts,
   output logic [9:0]       o_column,
   output logic [9:0]       o_start,
   output logic [9:0]       o_end,
   output logic             o_side,
   output logic             o_esc
);
   localparam int MW = $clog2(MAP_SIZE);
   localparam int AW = $clog2(MAP_SIZE*MAP_SIZE);
   localparam int CW = ((MW > 5) ? MW : 5) + 2; // signed map coord, holds 0..MAP_SIZE-1 plus margin

   logic [15:0] px_ff, py_ff;
   logic signed [15:0] sin_ff, cos_ff;
   logic [10:0] sw_ff, sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0; py_ff <= '0; sin_ff <= '0; cos_ff <= 16'sd16384;
         sw_ff <= 11'd640; sh_ff <= 11'd480;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PLAYER_X: px_ff  <= csr_wdata;
            REG_PLAYER_Y: py_ff  <= csr_wdata;
            REG_VIEW_SIN: sin_ff <= csr_wdata;
            REG_VIEW_COS: cos_ff <= csr_wdata;
            REG_SCREEN_W: sw_ff  <= csr_wdata[10:0];
            REG_SCREEN_H: sh_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // map memory
   logic [7:0] mem [MAP_SIZE*MAP_SIZE];
   logic [7:0] rd_ff;
   logic signed [CW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [AW-1:0] rd_addr;
   assign rd_addr = {mx_ff[MW-1:0], my_ff[MW-1:0]};
   always_ff @(posedge clock) begin
      if (clr_we) mem[clr_addr] <= 8'd0;
      else if (map_we) mem[{wr_x[MW-1:0], wr_y[MW-1:0]}] <= wr_val;
      rd_ff <= mem[rd_addr];
   end

   // working registers; camera offset reaches about 2^25 for columns past the width
   logic [9:0]  col_ff;
   logic [10:0] w_ff, h_ff;
   logic signed [26:0] cam_ff;
   logic signed [27:0] dx_ff, dy_ff;
   logic signed [42:0] mcos_ff, msin_ff;
   logic [31:0] ddx_ff, ddy_ff;
   logic [37:0] sdx_ff, sdy_ff;
   logic        side_ff;
   logic [31:0] perp_ff;
   logic [31:0] line_ff;

   // divider operand selection
   logic [63:0] dnum;
   logic [31:0] dden;
   logic        dneg;
   logic        ddone;
   logic [63:0] dquo;
   logic signed [12:0] camnum;
   logic [27:0] adx, ady;
   logic signed [17:0] pnum;
   logic [17:0] apnum;
   logic signed [27:0] pd;
   logic [27:0] apd;
   logic        pneg;

   assign camnum = $signed({2'b0, col_ff, 1'b0}) - $signed({2'b0, w_ff});
   assign adx = dx_ff[27] ? 28'(-dx_ff) : 28'(dx_ff);
   assign ady = dy_ff[27] ? 28'(-dy_ff) : 28'(dy_ff);
   assign pnum = side_ff
      ? 18'(($signed({{(18-CW){my_ff[CW-1]}}, my_ff}) <<< 11) - $signed({2'b0, py_ff})
            + (dy_ff[27] ? 18'sd2048 : 18'sd0))
      : 18'(($signed({{(18-CW){mx_ff[CW-1]}}, mx_ff}) <<< 11) - $signed({2'b0, px_ff})
            + (dx_ff[27] ? 18'sd2048 : 18'sd0));
   assign pd = side_ff ? dy_ff : dx_ff;
   assign apnum = pnum[17] ? 18'(-pnum) : 18'(pnum);
   assign apd   = pd[27] ? 28'(-pd) : 28'(pd);
   assign pneg  = 1'b0; // perp is an absolute value

   always_comb begin
      dnum = '0; dden = 32'd1; dneg = 1'b0;
      unique case (cmd.div_sel)
         DIV_CAM: begin
            dnum = 64'(camnum[12] ? 13'(-camnum) : 13'(camnum)) << 14;
            dden = 32'(w_ff); dneg = camnum[12];
         end
         DIV_DDX: begin dnum = 64'd1 << 30; dden = 32'(adx); end
         DIV_DDY: begin dnum = 64'd1 << 30; dden = 32'(ady); end
         DIV_PERP: begin dnum = 64'(apnum) << 19; dden = 32'(apd); dneg = pneg; end
         DIV_LINE: begin dnum = 64'(h_ff) << 16; dden = perp_ff; end
         default: ;
      endcase
   end

   drc_div u_div (.clock(clock), .reset(reset), .go(cmd.div_go), .num(dnum), .den(dden),
      .done(ddone), .quo(dquo));

   logic neg_ff;
   logic [63:0] side_prod_x, side_prod_y;
   logic [11:0] fx, fy;
   assign fx = dx_ff[27] ? {1'b0, px_ff[10:0]} : 12'd2048 - {1'b0, px_ff[10:0]};
   assign fy = dy_ff[27] ? {1'b0, py_ff[10:0]} : 12'd2048 - {1'b0, py_ff[10:0]};
   assign side_prod_x = 64'(fx) * 64'(ddx_ff);
   assign side_prod_y = 64'(fy) * 64'(ddy_ff);

   logic [10:0] hh;
   logic [30:0] lh;
   logic signed [32:0] ds_v, de_v;
   assign hh = h_ff >> 1;
   assign lh = line_ff[31:1];
   assign ds_v = $signed({22'b0, hh}) - $signed({2'b0, lh});
   assign de_v = $signed({2'b0, lh}) + $signed({22'b0, hh});

   always_comb begin
      mx_in = mx_ff; my_in = my_ff;
      if (cmd.load) begin
         mx_in = CW'(px_ff[15:11]); my_in = CW'(py_ff[15:11]);
      end else if (cmd.walk) begin
         if (sdx_ff < sdy_ff) mx_in = mx_ff + (dx_ff[27] ? -CW'(1) : CW'(1));
         else                 my_in = my_ff + (dy_ff[27] ? -CW'(1) : CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      mx_ff <= mx_in; my_ff <= my_in;
      if (cmd.load) begin
         col_ff <= req_column;
         w_ff <= (sw_ff == 11'd0) ? 11'd1 : sw_ff;
         h_ff <= (sh_ff == 11'd0) ? 11'd1 : sh_ff;
         neg_ff <= 1'b0;
      end
      if (cmd.div_go) neg_ff <= dneg;
      if (cmd.div_take) begin
         unique case (cmd.div_sel)
            DIV_CAM:  cam_ff <= neg_ff ? 27'(-dquo[26:0]) : dquo[26:0];
            DIV_DDX:  ddx_ff <= (adx == 28'd0) ? 32'h7FFF_FFFF : dquo[31:0];
            DIV_DDY:  ddy_ff <= (ady == 28'd0) ? 32'h7FFF_FFFF : dquo[31:0];
            // past 32 bits the line height comes out zero either way
            DIV_PERP: perp_ff <= (apd == 28'd0) ? 32'd0 :
                                 ((dquo[63:32] != 32'd0) ? 32'hFFFF_FFFF : dquo[31:0]);
            DIV_LINE: line_ff <= (perp_ff == 32'd0 || dquo > 64'h4000_0000)
                                 ? 32'h4000_0000 : dquo[31:0];
            default: ;
         endcase
      end
      if (cmd.dir_mul) begin
         mcos_ff <= 43'(cam_ff * cos_ff);
         msin_ff <= 43'(cam_ff * sin_ff);
      end
      if (cmd.dir_fin) begin
         dx_ff <= 28'(sin_ff) + 28'(mcos_ff >>> 14);
         dy_ff <= 28'(cos_ff) - 28'(msin_ff >>> 14);
      end
      if (cmd.side_mul) begin
         sdx_ff <= 38'(side_prod_x >> 11);
         sdy_ff <= 38'(side_prod_y >> 11);
      end
      if (cmd.walk) begin
         if (sdx_ff < sdy_ff) begin sdx_ff <= sdx_ff + 38'(ddx_ff); side_ff <= 1'b0; end
         else begin sdy_ff <= sdy_ff + 38'(ddy_ff); side_ff <= 1'b1; end
      end
      if (cmd.fin) begin
         o_column <= col_ff;
         o_esc    <= escaped_set;
         o_side   <= escaped_set ? 1'b0 : side_ff;
         o_start  <= escaped_set ? 10'd0 : (ds_v < 0 ? 10'd0 : ds_v[9:0]);
         o_end    <= escaped_set ? 10'd0 :
                     (de_v >= $signed({22'b0, h_ff}) ? 10'(h_ff - 11'd1) : de_v[9:0]);
      end
   end

   assign sts.div_done  = ddone;
   assign sts.out_map   = (mx_ff < 0) || (mx_ff >= CW'(MAP_SIZE))
                        || (my_ff < 0) || (my_ff >= CW'(MAP_SIZE));
   assign sts.wall      = rd_ff != 8'd0;
   assign sts.d_zero    = apd == 28'd0;
   assign sts.perp_zero = perp_ff == 32'd0;
endmodule
`default_nettype wire

/* sv/drc_ctrl.sv */
// Controller: sequences the map clear, map writes, divides, DDA walk and result strobe.
`default_nettype none
module drc_ctrl import drc_pkg::*; #(
   parameter int MAP_SIZE  = MAP_SIZE_DEF,
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_start,
   input  wire logic   req_op,
   input  drc_sts_type sts,
   output drc_cmd_type cmd,
   output logic        busy,
   output logic        clr_we,
   output logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0] clr_addr,
   output logic        map_we,
   output logic        esc,
   output logic        strobe
);
   localparam int AW = $clog2(MAP_SIZE*MAP_SIZE);
   localparam int SW = $clog2(MAX_STEPS+1);
   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_DIV = 4'd2, S_DIVW = 4'd3,
      S_MUL = 4'd4, S_DIR = 4'd5, S_SIDE = 4'd6, S_STEP = 4'd7, S_RD = 4'd8,
      S_TEST = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11;

   logic [3:0] st_ff, st_in;
   logic [2:0] sel_ff, sel_in;
   logic [AW:0] ca_ff, ca_in;
   logic [SW-1:0] n_ff, n_in;
   logic esc_ff, esc_in;

   always_comb begin
      st_in = st_ff; sel_in = sel_ff; ca_in = ca_ff; n_in = n_ff; esc_in = esc_ff;
      cmd = '0; cmd.div_sel = sel_ff; map_we = 1'b0; strobe = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            ca_in = ca_ff + 1'b1;
            if (ca_ff == (AW+1)'(MAP_SIZE*MAP_SIZE-1)) st_in = S_IDLE;
         end
         S_IDLE: if (req_start) begin
            if (req_op == OP_WRITE) map_we = 1'b1;
            else begin
               cmd.load = 1'b1; sel_in = DIV_CAM; esc_in = 1'b0; n_in = '0;
               st_in = S_DIV;
            end
         end
         S_DIV: begin cmd.div_go = 1'b1; st_in = S_DIVW; end
         S_DIVW: if (sts.div_done) begin
            cmd.div_take = 1'b1;
            unique case (sel_ff)
               DIV_CAM:  st_in = S_MUL;
               DIV_DDX:  begin sel_in = DIV_DDY; st_in = S_DIV; end
               DIV_DDY:  st_in = S_SIDE;
               DIV_PERP: begin sel_in = DIV_LINE; st_in = S_DIV; end
               default:  st_in = S_FIN;
            endcase
         end
         S_MUL: begin cmd.dir_mul = 1'b1; st_in = S_DIR; end
         S_DIR: begin cmd.dir_fin = 1'b1; sel_in = DIV_DDX; st_in = S_DIV; end
         S_SIDE: begin cmd.side_mul = 1'b1; st_in = S_STEP; end
         S_STEP: begin
            cmd.walk = 1'b1; n_in = n_ff + 1'b1; st_in = S_RD;
         end
         S_RD: begin
            if (sts.out_map) begin esc_in = 1'b1; st_in = S_FIN; end
            else st_in = S_TEST;
         end
         S_TEST: begin
            if (sts.wall) begin sel_in = DIV_PERP; st_in = S_DIV; end
            else if (n_ff == SW'(MAX_STEPS)) begin esc_in = 1'b1; st_in = S_FIN; end
            else st_in = S_STEP;
         end
         S_FIN: begin cmd.fin = 1'b1; st_in = S_OUT; end
         S_OUT: begin strobe = 1'b1; st_in = S_IDLE; end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; ca_ff <= '0; sel_ff <= DIV_CAM; n_ff <= '0; esc_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ca_ff <= ca_in; sel_ff <= sel_in; n_ff <= n_in; esc_ff <= esc_in;
      end
   end

   assign busy     = st_ff != S_IDLE;
   assign clr_we   = st_ff == S_CLEAR;
   assign clr_addr = ca_ff[AW-1:0];
   assign esc      = esc_ff;
endmodule
`default_nettype wire

/* sv/dda_ray_column_caster.sv */
// Top level: grid DDA ray caster, one wall slice per cast transfer.
`default_nettype none
// A transfer is taken when start is high and busy low. A map write gives no
// result. A cast runs its divides on one shared bit-serial divider with a
// 64-bit quotient: camera offset, two delta distances, then on a hit
// perpendicular distance and line height, with the DDA steps (states S_STEP,
// S_RD, S_TEST) between them, up to MAX_STEPS steps. An escaped ray skips the
// last two divides. The result is shown for one cycle on rsp_valid; the
// receiver cannot stall. After reset a clearing pass zeroes the map while
// busy stays high; csr writes are taken meanwhile.
module dda_ray_column_caster import drc_pkg::*; #(
   parameter int MAP_SIZE  = MAP_SIZE_DEF,
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [9:0]  req_column,
   input  wire logic [4:0]  req_cell_x,
   input  wire logic [4:0]  req_cell_y,
   input  wire logic [7:0]  req_cell_value,
   output logic             rsp_valid,
   output logic [9:0]       rsp_result_column,
   output logic [9:0]       rsp_draw_start,
   output logic [9:0]       rsp_draw_end,
   output logic             rsp_hit_side,
   output logic             rsp_escaped,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   drc_cmd_type cmd;
   drc_sts_type sts;
   logic clr_we, map_we, esc, wr_ok;
   logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0] clr_addr;

   // writes outside the map are dropped
   assign wr_ok = (32'(req_cell_x) < MAP_SIZE) && (32'(req_cell_y) < MAP_SIZE);

   drc_ctrl #(.MAP_SIZE(MAP_SIZE), .MAX_STEPS(MAX_STEPS)) u_ctrl (
      .clock(clock), .reset(reset), .req_start(start), .req_op(req_op), .sts(sts),
      .cmd(cmd), .busy(busy), .clr_we(clr_we), .clr_addr(clr_addr), .map_we(map_we),
      .esc(esc), .strobe(rsp_valid));

   drc_datapath #(.MAP_SIZE(MAP_SIZE)) u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .map_we(map_we && wr_ok), .wr_x(req_cell_x),
      .wr_y(req_cell_y), .wr_val(req_cell_value), .clr_we(clr_we), .clr_addr(clr_addr),
      .req_column(req_column), .cmd(cmd), .escaped_set(esc), .sts(sts),
      .o_column(rsp_result_column), .o_start(rsp_draw_start), .o_end(rsp_draw_end),
      .o_side(rsp_hit_side), .o_esc(rsp_escaped));

`include "assert_macros.svh"
   // no transfer is taken while busy, so a strobe never meets a start
   `ASSERT_IMP(a_no_strobe_idle, clock, reset, rsp_valid, busy)
   // the result goes back to idle right after its strobe
   `ASSERT_NXT(a_idle_after_out, clock, reset, rsp_valid, !busy)
   // an escaped ray reports a blank slice
   `ASSERT_IMP(a_esc_blank, clock, reset, rsp_valid && rsp_escaped,
      rsp_draw_start == 10'd0 && rsp_draw_end == 10'd0 && !rsp_hit_side)
endmodule
`default_nettype wire
